@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define BFD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define BFD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

// cond must never hold
`define BFD_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error(msg);

`endif

@@ rtl/bfd_pkg.sv @@
package bfd_pkg;

    // result kinds
    typedef enum logic [2:0] {
        KIND_ECHO  = 3'd0,
        KIND_ERROR = 3'd1,
        KIND_OBJ   = 3'd2,
        KIND_VAL   = 3'd3,
        KIND_END   = 3'd4
    } kind_t;

    // parser phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_OBJECT = 2'd1,
        PH_VALUE  = 2'd2
    } phase_t;

    // parser state update applied by the datapath
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_BYTE,
        UPD_IDLE,
        UPD_RELEASE
    } upd_t;

    // release index control
    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLEAR,
        IDX_STEP
    } idx_op_t;

    localparam logic [7:0] CH_PRINT_LO = 8'h21;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_ERR      = 8'h3F;  // '?'
    localparam logic [7:0] CH_OPEN     = 8'h7B;  // '{'
    localparam logic [7:0] CH_CLOSE    = 8'h7D;  // '}'
    localparam logic [7:0] CH_COLON    = 8'h3A;  // ':'
    localparam logic [7:0] CH_COMMA    = 8'h2C;  // ','

    typedef struct packed {
        logic    take;     // input side open
        logic    accept;   // input transaction this cycle
        logic    fire;     // load output register
        kind_t   kind;
        logic    last;
        upd_t    upd;
        idx_op_t idx_op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;   // output register empty or draining
        logic is_err;      // held byte gives an error marker
        logic is_release;  // held byte closes a record
        logic obj_zero;    // no object characters to release
        logic val_zero;    // no value characters to release
        logic obj_done;    // index at last object character
        logic val_done;    // index at last value character
    } ctrl_sts_t;

endpackage

@@ rtl/brace_record_deframer.sv @@
// Brace record deframer. Takes one received byte per input transaction and
// answers with a burst of result transactions: always an echo of the byte
// first, then possibly an error marker ('?'), or, when a comma or closing
// brace ends a value, the buffered object characters, the buffered value
// characters and a record-end item carrying the overflow flag. The final
// result of each byte has last set. After a byte is taken, its results leave
// at one per cycle while the output is not stalled, all through the single
// output register that the controller loads. The next byte is taken only
// after the last result of the current one has been loaded. Each of the two
// character stores is a MAX_CHARS-deep RAM with registered read; entries are
// only read back after being written in the same record, so no clearing
// pass is needed after reset. Characters beyond MAX_CHARS in one field are
// dropped and reported on the record end.
module brace_record_deframer #(
    parameter int MAX_CHARS = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    // byte input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // result output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] data,
    output logic       overflow,
    output logic       last
);
    import bfd_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Controller: sequences echo, error, release and record end.
    bfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: parser state, character stores and output register.
    bfd_dp #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .overflow  (overflow),
        .last      (last)
    );

    // input side is open only while the controller waits for a byte
    assign in_stall = !cmd.take;

endmodule

@@ rtl/bfd_ram.sv @@
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bfd_ctrl.sv @@
`include "assert_macros.svh"

module bfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bfd_pkg::ctrl_sts_t  sts,
    output bfd_pkg::ctrl_cmd_t  cmd
);
    import bfd_pkg::*;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_ECHO,
        ST_ERR,
        ST_OBJ,
        ST_VAL,
        ST_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.take    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.fire    = 1'b0;
        cmd.kind    = KIND_ECHO;
        cmd.last    = 1'b0;
        cmd.upd     = UPD_NONE;
        cmd.idx_op  = IDX_HOLD;
        unique case (state_reg)
            ST_WAIT:
            begin
                cmd.take   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_ECHO;
                end
            end
            ST_ECHO:
            begin
                cmd.kind = KIND_ECHO;
                cmd.last = !(sts.is_err || sts.is_release);
                cmd.fire = sts.slot_free;
                if (sts.slot_free)
                begin
                    if (sts.is_err)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (sts.is_release)
                    begin
                        cmd.idx_op = IDX_CLEAR;
                        if (!sts.obj_zero)
                        begin
                            state_next = ST_OBJ;
                        end
                        else if (!sts.val_zero)
                        begin
                            state_next = ST_VAL;
                        end
                        else
                        begin
                            state_next = ST_END;
                        end
                    end
                    else
                    begin
                        cmd.upd    = UPD_BYTE;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_ERR:
            begin
                cmd.kind = KIND_ERROR;
                cmd.last = 1'b1;
                cmd.fire = sts.slot_free;
                if (sts.slot_free)
                begin
                    cmd.upd    = UPD_IDLE;
                    state_next = ST_WAIT;
                end
            end
            ST_OBJ:
            begin
                cmd.kind = KIND_OBJ;
                cmd.fire = sts.slot_free;
                if (sts.slot_free)
                begin
                    if (sts.obj_done)
                    begin
                        cmd.idx_op = IDX_CLEAR;
                        state_next = sts.val_zero ? ST_END : ST_VAL;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_STEP;
                    end
                end
            end
            ST_VAL:
            begin
                cmd.kind = KIND_VAL;
                cmd.fire = sts.slot_free;
                if (sts.slot_free)
                begin
                    if (sts.val_done)
                    begin
                        cmd.idx_op = IDX_CLEAR;
                        state_next = ST_END;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_STEP;
                    end
                end
            end
            ST_END:
            begin
                cmd.kind = KIND_END;
                cmd.last = 1'b1;
                cmd.fire = sts.slot_free;
                if (sts.slot_free)
                begin
                    cmd.upd    = UPD_RELEASE;
                    state_next = ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a new byte is never taken while a result is being produced
    `BFD_ASSERT_NEVER(a_no_accept_on_fire, clk, rst_n, cmd.accept && cmd.fire,
        "byte accepted while emitting")
    // the final result of a byte reopens the input side
    `BFD_ASSERT_NXT(a_last_reopens, clk, rst_n, cmd.fire && cmd.last,
        state_reg == ST_WAIT, "input not reopened after last result")

endmodule

@@ rtl/bfd_dp.sv @@
`include "assert_macros.svh"

module bfd_dp #(
    parameter int MAX_CHARS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bfd_pkg::ctrl_cmd_t cmd,
    output bfd_pkg::ctrl_sts_t sts,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [7:0]         data,
    output logic               overflow,
    output logic               last
);
    import bfd_pkg::*;

    localparam int AW = $clog2(MAX_CHARS);
    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHARS);

    // parser state
    phase_t          phase_reg;
    phase_t          phase_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [CW-1:0]   obj_len_reg;
    logic [CW-1:0]   obj_len_next;
    logic            ovf_seen_reg;
    logic            ovf_seen_next;
    logic [7:0]      byte_reg;

    // release index
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   idx_next;

    // output register
    logic            out_valid_reg;
    kind_t           kind_reg;
    logic [7:0]      data_reg;
    logic            ovf_reg;
    logic            last_reg;
    logic [7:0]      data_sel;

    // stores
    logic            obj_we;
    logic            val_we;
    logic [7:0]      obj_rdata;
    logic [7:0]      val_rdata;

    logic            is_print;
    logic            is_sep;
    logic [CW:0]     idx_inc;

    assign is_print = (byte_reg >= CH_PRINT_LO) && (byte_reg <= CH_PRINT_HI);
    assign is_sep   = (byte_reg == CH_COMMA) || (byte_reg == CH_CLOSE);
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;

    always_comb
    begin
        sts.slot_free  = !out_valid_reg || !out_stall;
        sts.is_err     = !is_print || (is_sep && phase_reg == PH_OBJECT);
        sts.is_release = is_print && is_sep && phase_reg == PH_VALUE;
        sts.obj_zero   = obj_len_reg == '0;
        sts.val_zero   = cnt_reg == '0;
        sts.obj_done   = idx_inc == {1'b0, obj_len_reg};
        sts.val_done   = idx_inc == {1'b0, cnt_reg};
    end

    // plain characters go to the store of the current phase
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        obj_len_next  = obj_len_reg;
        ovf_seen_next = ovf_seen_reg;
        obj_we        = 1'b0;
        val_we        = 1'b0;
        unique case (cmd.upd)
            UPD_NONE:
            begin
            end
            UPD_BYTE:
            begin
                if (byte_reg == CH_OPEN)
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next    = PH_OBJECT;
                        cnt_next      = '0;
                        ovf_seen_next = 1'b0;
                    end
                end
                else if (byte_reg == CH_COLON)
                begin
                    if (phase_reg == PH_OBJECT)
                    begin
                        obj_len_next = cnt_reg;
                        phase_next   = PH_VALUE;
                        cnt_next     = '0;
                    end
                end
                else if (!is_sep && phase_reg != PH_IDLE)
                begin
                    if (cnt_reg < MAX_CNT)
                    begin
                        obj_we   = phase_reg == PH_OBJECT;
                        val_we   = phase_reg == PH_VALUE;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_seen_next = 1'b1;
                    end
                end
            end
            UPD_IDLE:
            begin
                phase_next    = PH_IDLE;
                cnt_next      = '0;
                ovf_seen_next = 1'b0;
            end
            UPD_RELEASE:
            begin
                phase_next    = (byte_reg == CH_COMMA) ? PH_OBJECT : PH_IDLE;
                cnt_next      = '0;
                ovf_seen_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // read address runs one ahead so the store output matches idx_reg
    always_comb
    begin
        unique case (cmd.idx_op)
            IDX_HOLD:  idx_next = idx_reg;
            IDX_CLEAR: idx_next = '0;
            IDX_STEP:  idx_next = idx_inc[CW-1:0];
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.kind)
            KIND_ECHO:  data_sel = byte_reg;
            KIND_ERROR: data_sel = CH_ERR;
            KIND_OBJ:   data_sel = obj_rdata;
            KIND_VAL:   data_sel = val_rdata;
            KIND_END:   data_sel = 8'h00;
            default:    data_sel = 8'h00;
        endcase
    end

    bfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHARS)
    ) u_obj_ram (
        .clk   (clk),
        .we    (obj_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (idx_next[AW-1:0]),
        .rdata (obj_rdata)
    );

    bfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHARS)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (idx_next[AW-1:0]),
        .rdata (val_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            obj_len_reg   <= '0;
            ovf_seen_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            obj_len_reg  <= obj_len_next;
            ovf_seen_reg <= ovf_seen_next;
            idx_reg      <= idx_next;
            if (cmd.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= rx_byte;
        end
        if (cmd.fire)
        begin
            kind_reg <= cmd.kind;
            data_reg <= data_sel;
            ovf_reg  <= (cmd.kind == KIND_END) ? ovf_seen_reg : 1'b0;
            last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign overflow  = ovf_reg;
    assign last      = last_reg;

    `BFD_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= MAX_CNT,
        "character count beyond store size")
    `BFD_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid_reg && kind_reg == KIND_END,
        last_reg, "record end not marked last")

endmodule

@@ tb/brace_record_deframer_tb.sv @@
`timescale 1ns / 1ps

module brace_record_deframer_tb;

    import bfd_pkg::*;

    localparam int CAP          = 15;      // characters per store
    localparam int SCRIPT_LEN   = 25;
    localparam int RAND_ITEMS   = 350;
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;      // longer than the longest burst
    localparam int LIMIT_CYCLES = 200000;
    localparam int SHOW_MAX     = 10;

    // One expected result transaction.
    typedef struct packed {
        kind_t      k;
        logic [7:0] d;
        logic       ovf;
        logic       fin;
    } res_t;

    // One directed row. When typed is set, the expected burst is the echo,
    // plus one extra result if extra is set, taken from the row itself.
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        logic       extra;
        kind_t      x_kind;
        logic [7:0] x_data;
        logic       x_ovf;
    } row_t;

    // Directed sequence: printable range extremes, framing characters in each
    // phase, an empty record, a release by comma, errors in each phase.
    localparam row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        '{CH_PRINT_LO, 1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},  // printable in idle
        '{CH_PRINT_HI, 1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{8'h00,       1'b1, 1'b1, KIND_ERROR, CH_ERR, 1'b0},  // non-printable
        '{8'hFF,       1'b1, 1'b1, KIND_ERROR, CH_ERR, 1'b0},
        '{CH_COLON,    1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},  // framing in idle
        '{CH_CLOSE,    1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{CH_COMMA,    1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{CH_OPEN,     1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},  // idle -> object
        '{CH_OPEN,     1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},  // brace in object
        '{CH_COMMA,    1'b1, 1'b1, KIND_ERROR, CH_ERR, 1'b0},  // comma in object
        '{CH_OPEN,     1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{CH_COLON,    1'b1, 1'b0, KIND_ECHO,  8'h00,  1'b0},  // empty object
        '{CH_CLOSE,    1'b1, 1'b1, KIND_END,   8'h00,  1'b0},  // empty record
        '{CH_OPEN,     1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{8'h61,       1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{CH_COLON,    1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{CH_COLON,    1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},  // colon in value
        '{CH_OPEN,     1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},  // brace in value
        '{8'h31,       1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{CH_COMMA,    1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},  // release, stay open
        '{8'h62,       1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{CH_COLON,    1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{8'h32,       1'b0, 1'b0, KIND_ECHO,  8'h00,  1'b0},
        '{8'h20,       1'b1, 1'b1, KIND_ERROR, CH_ERR, 1'b0},  // space in value
        '{8'h7F,       1'b1, 1'b1, KIND_ERROR, CH_ERR, 1'b0}   // DEL in idle
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] kind;
    logic [7:0] data;
    logic       overflow;
    logic       last;

    // shared flags between stimulus and receiver
    logic quiet    = 1'b0;   // no idling on either side
    logic hold_req = 1'b0;   // ask receiver for the long hold-off
    logic hold_taken;

    // predictor state
    phase_t     ph      = PH_IDLE;
    int         fill    = 0;
    int         obj_len = 0;
    logic       dropped = 1'b0;
    logic [7:0] obj_mem [CAP];
    logic [7:0] val_mem [CAP];

    res_t burst_q[$];   // results of the byte just predicted
    res_t want_q[$];    // results still awaited from the block
    row_t plan_q[$];    // rows offered, popped on acceptance

    int errors    = 0;
    int cycles    = 0;
    int n_rand    = 0;
    int n_bytes   = 0;
    int n_results = 0;
    int n_records = 0;
    int n_dropped = 0;
    int n_marks   = 0;

    brace_record_deframer #(
        .MAX_CHARS(CAP)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .data     (data),
        .overflow (overflow),
        .last     (last)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: one received byte in, its burst of results in burst_q.
    // ------------------------------------------------------------------
    task automatic put(input kind_t k, input logic [7:0] d, input logic ovf);
        res_t r;
        r = '{k, d, ovf, 1'b0};
        burst_q.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] c);
        int   i;
        res_t r;
        burst_q.delete();
        put(KIND_ECHO, c, 1'b0);               // echo always leads
        if (c < CH_PRINT_LO || c > CH_PRINT_HI) begin
            // non-printable: error marker in any phase, record dropped
            put(KIND_ERROR, CH_ERR, 1'b0);
            ph      = PH_IDLE;
            fill    = 0;
            dropped = 1'b0;
        end else if (c == CH_OPEN) begin
            if (ph == PH_IDLE) begin
                ph      = PH_OBJECT;
                fill    = 0;
                dropped = 1'b0;
            end
        end else if (c == CH_COLON) begin
            if (ph == PH_OBJECT) begin
                obj_len = fill;
                ph      = PH_VALUE;
                fill    = 0;
            end
        end else if (c == CH_COMMA || c == CH_CLOSE) begin
            if (ph == PH_VALUE) begin
                // release: object chars, value chars, then record end
                for (i = 0; i < obj_len; i++)
                    put(KIND_OBJ, obj_mem[i], 1'b0);
                for (i = 0; i < fill; i++)
                    put(KIND_VAL, val_mem[i], 1'b0);
                put(KIND_END, 8'h00, dropped);
                ph      = (c == CH_COMMA) ? PH_OBJECT : PH_IDLE;
                fill    = 0;
                dropped = 1'b0;
            end else if (ph == PH_OBJECT) begin
                put(KIND_ERROR, CH_ERR, 1'b0);
                ph      = PH_IDLE;
                fill    = 0;
                dropped = 1'b0;
            end
        end else if (ph != PH_IDLE) begin
            if (fill < CAP) begin
                if (ph == PH_OBJECT)
                    obj_mem[fill] = c;
                else
                    val_mem[fill] = c;
                fill++;
            end else begin
                dropped = 1'b1;             // store full, char lost
            end
        end
        r = burst_q.pop_back();
        r.fin = 1'b1;
        burst_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on every input transaction, checks every output
    // transaction against the oldest expectation. Sampled at rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        res_t w;
        row_t plan;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                n_bytes++;
                plan = plan_q.pop_front();
                deframe_byte(rx_byte);
                if (plan.typed) begin
                    // hand-written expectation for this directed row
                    w = '{KIND_ECHO, rx_byte, 1'b0, !plan.extra};
                    want_q.push_back(w);
                    if (plan.extra) begin
                        w = '{plan.x_kind, plan.x_data, plan.x_ovf, 1'b1};
                        want_q.push_back(w);
                    end
                end else begin
                    while (burst_q.size() != 0)
                        want_q.push_back(burst_q.pop_front());
                end
            end
            if (out_valid && !out_stall) begin
                n_results++;
                if (kind == KIND_END) begin
                    n_records++;
                    if (overflow) n_dropped++;
                end
                if (kind == KIND_ERROR) n_marks++;
                if (want_q.size() == 0) begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display("%0t: unexpected result kind=%0d data=%02h ovf=%0b last=%0b",
                                 $realtime, kind, data, overflow, last);
                end else begin
                    w = want_q.pop_front();
                    if (kind !== w.k || data !== w.d || overflow !== w.ovf
                        || last !== w.fin) begin
                        errors++;
                        if (errors <= SHOW_MAX)
                            $display({"%0t: result %0d exp kind=%0d data=%02h ovf=%0b ",
                                      "last=%0b got kind=%0d data=%02h ovf=%0b last=%0b"},
                                     $realtime, n_results, w.k, w.d, w.ovf, w.fin,
                                     kind, data, overflow, last);
                    end
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, want_q.size());
            $display("brace_record_deframer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall about 14% of cycles, none while quiet, plus
    // one long hold-off so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        int k;
        out_stall  = 1'b0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                for (k = 1; k < HOLD_CYCLES; k++)
                    @(negedge clk);
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 14);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Inputs change on the falling edge; a transaction
    // completes at the first rising edge where in_stall is low.
    // ------------------------------------------------------------------
    task automatic offer(input row_t r);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= r.b;
        plan_q.push_back(r);
        do @(posedge clk); while (in_stall);
    endtask

    task automatic offer_byte(input logic [7:0] b);
        row_t r;
        r = '{b, 1'b0, 1'b0, KIND_ECHO, 8'h00, 1'b0};
        offer(r);
        n_rand++;
    endtask

    // printable, not a framing character
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        while (c == CH_OPEN || c == CH_CLOSE || c == CH_COLON || c == CH_COMMA);
        return c;
    endfunction

    // one object or value field; a few bytes are raw noise
    task automatic offer_field(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 3)
                offer_byte(8'($urandom_range(0, 255)));
            else
                offer_byte(text_char());
        end
    endtask

    initial begin : stimulus
        int k;
        int pairs;
        int p;
        logic big;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < SCRIPT_LEN; k++)
            offer(SCRIPT[k]);

        // Mostly well-formed records with random content; long fields
        // push the stores past capacity. Noise bytes break records.
        while (n_rand < RAND_ITEMS) begin
            quiet = (n_rand >= 150 && n_rand < 220);
            if (n_rand >= 80)
                hold_req = 1'b1;
            if ($urandom_range(0, 99) < 10) begin
                offer_byte(8'($urandom_range(0, 255)));
            end else begin
                offer_byte(CH_OPEN);
                pairs = $urandom_range(1, 3);
                for (p = 0; p < pairs; p++) begin
                    big = ($urandom_range(0, 99) < 12);
                    offer_field(big ? $urandom_range(CAP - 2, CAP + 3)
                                    : $urandom_range(0, 5));
                    offer_byte(CH_COLON);
                    offer_field(big ? $urandom_range(CAP - 2, CAP + 3)
                                    : $urandom_range(0, 5));
                    offer_byte((p == pairs - 1) ? CH_CLOSE : CH_COMMA);
                end
            end
        end
        quiet = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d bytes in, %0d results out, %0d records released",
                 n_bytes, n_results, n_records);
        $display("run: %0d records with dropped chars, %0d error markers, %0d failures",
                 n_dropped, n_marks, errors);
        if (errors == 0)
            $display("brace_record_deframer: match");
        else
            $display("brace_record_deframer: mismatch");
        $finish;
    end

endmodule
